// ===== rtl/drrn_pkg.sv =====
// ----------------------------------------------------------------------------
// drrn_pkg
// Shared types, command and register codes, and rate lookup tables for the
// delayed recurrent rate network step block.
// ----------------------------------------------------------------------------
package drrn_pkg;

    // default sizes
    localparam int CELLS_DEF     = 32;
    localparam int CONN_DEF      = 32;
    localparam int MAX_DELAY_DEF = 16;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 39;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // configuration port widths
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_DRIVE = 2'd2;
    localparam logic [1:0] CMD_STEP  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEAK      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REC_SCALE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLOB_INH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_INH   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SIG   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_GAIN  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_THR   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN = 4'd7;

    // register reset values
    localparam logic [15:0] LEAK_RST      = 16'd6554;
    localparam logic [15:0] REC_SCALE_RST = 16'd4096;
    localparam logic [15:0] SIG_GAIN_RST  = 16'd4096;

    // input word
    typedef struct packed {
        logic [1:0]         cmd;
        logic [4:0]         target_cell;
        logic [4:0]         slot;
        logic [4:0]         source_cell;
        logic signed [15:0] value;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [4:0]         cell_index;
        logic signed [15:0] activation_out;
        logic [15:0]        rate_out;
        logic               last;
    } out_word_t;

    // sigmoid samples at steps of 0.5 over [0, 8]
    localparam logic [15:0] SIG_TAB [0:16] = '{
        16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
        16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };

    // tanh samples at steps of 0.25 over [0, 4]
    localparam logic [15:0] TANH_TAB [0:16] = '{
        16'd0,     16'd16051, 16'd30285, 16'd41625, 16'd49912, 16'd55593,
        16'd59320, 16'd61694, 16'd63179, 16'd64096, 16'd64659, 16'd65003,
        16'd65212, 16'd65338, 16'd65417, 16'd65464, 16'd65492
    };

endpackage

// ===== rtl/drrn_mul.sv =====
// ----------------------------------------------------------------------------
// drrn_mul
// Shared signed multiplier with a registered product, reused for every
// product of a network step.
// ----------------------------------------------------------------------------
module drrn_mul (
    input  logic                                 clk,
    input  logic signed [drrn_pkg::MUL_A_W-1:0]  a,
    input  logic signed [drrn_pkg::MUL_B_W-1:0]  b,
    output logic signed [drrn_pkg::MUL_P_W-1:0]  p
);

    // product register
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

// ===== rtl/delayed_recurrent_rate_network_step.sv =====
// ----------------------------------------------------------------------------
// delayed_recurrent_rate_network_step
// Recurrent network of leaky rate cells, one timestep per step word, built
// around one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// a step runs one multiply-accumulate per connection of each cell through the
//   shared multiplier
// load, drive, register words act on acceptance; one word in flight at a time
// clear and reset: a zeroing pass over the delay memory, with no input word
//   taken meanwhile
// reset restores register defaults and zeroes drives, activations and rates
module delayed_recurrent_rate_network_step #(
    parameter int CELLS       = drrn_pkg::CELLS_DEF,
    parameter int CONNECTIONS = drrn_pkg::CONN_DEF,
    parameter int MAX_DELAY   = drrn_pkg::MAX_DELAY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drrn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drrn_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  drrn_pkg::in_word_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output drrn_pkg::out_word_t                 out_word
);

    localparam int CW  = $clog2(CELLS);
    localparam int KW  = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int DW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int AW  = drrn_pkg::MUL_A_W;
    localparam int BW  = drrn_pkg::MUL_B_W;
    localparam int PW  = drrn_pkg::MUL_P_W;
    localparam int WT_DEPTH = CELLS << KW;
    localparam int DL_DEPTH = CELLS << DW;
    localparam int SW  = CW + DW;
    localparam int SUMW = 16 + CW + 1;

    // sequencer codes
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SWEEP = 5'd1;
    localparam logic [4:0] ST_SUM   = 5'd2;
    localparam logic [4:0] ST_INH   = 5'd3;
    localparam logic [4:0] ST_INH_W = 5'd4;
    localparam logic [4:0] ST_MAC   = 5'd5;
    localparam logic [4:0] ST_DRAIN = 5'd6;
    localparam logic [4:0] ST_REC   = 5'd7;
    localparam logic [4:0] ST_REC_W = 5'd8;
    localparam logic [4:0] ST_LK1   = 5'd9;
    localparam logic [4:0] ST_LK2   = 5'd10;
    localparam logic [4:0] ST_LK3   = 5'd11;
    localparam logic [4:0] ST_RT1   = 5'd12;
    localparam logic [4:0] ST_RT2   = 5'd13;
    localparam logic [4:0] ST_RT3   = 5'd14;
    localparam logic [4:0] ST_RT4   = 5'd15;
    localparam logic [4:0] ST_OUT   = 5'd16;
    localparam logic [4:0] ST_WB    = 5'd17;

    // configuration registers
    logic [15:0]        leak_reg, rscale_reg, ginh_reg, beta_reg;
    logic signed [15:0] xinh_reg, alpha_reg;
    logic               use_sig_reg;
    logic [4:0]         dlen_reg;

    // sequencer and counters
    logic [4:0]         state_reg, state_next;
    logic               sweep_all_reg;
    logic [SW-1:0]      sweep_reg;
    logic [CW-1:0]      c_reg;
    logic [KW-1:0]      k_reg;
    logic [CW:0]        cnt_reg;
    logic [DW-1:0]      head_reg;

    // datapath registers
    logic [SUMW-1:0]        sum_reg;
    logic                   sum_v_reg;
    logic [16:0]            inh_reg;
    logic signed [AW-1:0]   acc_reg;
    logic                   v1_reg, v2_reg, v3_reg;
    logic signed [15:0]     w_d_reg;
    logic signed [24:0]     t_reg;
    logic signed [PW-1:0]   lk_reg;
    logic signed [15:0]     act_new_reg;
    logic [3:0]             idx_reg;
    logic [18:0]            frac_reg;
    logic                   neg_reg, sat_reg, zero_reg;
    logic                   wb_v_reg;
    logic [CW-1:0]          wb_cell_reg;
    logic                   out_valid_reg;
    drrn_pkg::out_word_t    out_word_reg;

    // memory read data
    logic signed [15:0]     w_q;
    logic [CW-1:0]          s_q;
    logic [15:0]            r_q;
    logic [15:0]            rate_q;
    logic signed [15:0]     act_q;
    logic signed [15:0]     drive_q;

    // memories
    logic [15:0]    wt_mem    [WT_DEPTH];
    logic [CW-1:0]  src_mem   [WT_DEPTH];
    logic [15:0]    dl_mem    [DL_DEPTH];
    logic [15:0]    rate_mem  [CELLS];
    logic [15:0]    act_mem   [CELLS];
    logic [15:0]    drive_mem [CELLS];

    // shared multiplier
    logic signed [AW-1:0]   mul_a;
    logic signed [BW-1:0]   mul_b;
    logic signed [PW-1:0]   mul_p;

    drrn_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // handshakes
    logic in_acc, cfg_acc;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // delay length in use and head position
    logic [7:0]     len8, head_inc8;
    logic [DW-1:0]  head_use, head_after;
    always_comb
    begin
        if (dlen_reg == 5'd0)
            len8 = 8'd1;
        else if (8'(dlen_reg) > 8'(MAX_DELAY))
            len8 = 8'(MAX_DELAY);
        else
            len8 = 8'(dlen_reg);
        head_use   = (8'(head_reg) < len8) ? head_reg : '0;
        head_inc8  = 8'(head_use) + 8'd1;
        head_after = (head_inc8 >= len8) ? '0 : DW'(head_inc8);
    end

    // input range checks
    logic load_ok, drive_ok;
    assign load_ok  = (32'(in_word.target_cell) < CELLS) &&
                      (32'(in_word.slot) < CONNECTIONS) &&
                      (32'(in_word.source_cell) < CELLS);
    assign drive_ok = (32'(in_word.target_cell) < CELLS);

    // table lookups for the rate stage
    logic [4:0]     idx_hi;
    logic [15:0]    tab_lo, tab_hi, tab_top, tab_diff;
    always_comb
    begin
        idx_hi   = {1'b0, idx_reg} + 5'd1;
        tab_lo   = use_sig_reg ? drrn_pkg::SIG_TAB[idx_reg] : drrn_pkg::TANH_TAB[idx_reg];
        tab_hi   = use_sig_reg ? drrn_pkg::SIG_TAB[idx_hi] : drrn_pkg::TANH_TAB[idx_hi];
        tab_top  = use_sig_reg ? drrn_pkg::SIG_TAB[16] : drrn_pkg::TANH_TAB[16];
        tab_diff = tab_hi - tab_lo;
    end

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_INH:
            begin
                mul_a = $signed(AW'(sum_reg));
                mul_b = $signed(BW'(ginh_reg));
            end
            ST_REC:
            begin
                mul_a = acc_reg;
                mul_b = $signed(BW'(rscale_reg));
            end
            ST_LK1:
            begin
                mul_a = AW'(act_q);
                mul_b = $signed(BW'(17'h10000 - {1'b0, leak_reg}));
            end
            ST_LK2:
            begin
                mul_a = AW'(t_reg);
                mul_b = $signed(BW'(leak_reg));
            end
            ST_RT1:
            begin
                mul_a = AW'($signed({act_new_reg[15], act_new_reg}) -
                            $signed({alpha_reg[15], alpha_reg}));
                mul_b = $signed(BW'(beta_reg));
            end
            ST_RT3:
            begin
                mul_a = $signed(AW'(frac_reg));
                mul_b = $signed(BW'(tab_diff));
            end
            default:
            begin
                mul_a = AW'(w_d_reg);
                mul_b = $signed(BW'(r_q));
            end
        endcase
    end

    // arithmetic on the product
    logic signed [PW-1:0]   rec_rnd, lk_sum, mag, rt_rnd;
    logic signed [22:0]     rec;
    logic signed [24:0]     t_val;
    logic signed [40:0]     a_wide;
    logic signed [15:0]     a_sat;
    logic [15:0]            rt_sh;
    logic [16:0]            v17, rate17;
    logic [15:0]            rate_val;
    always_comb
    begin
        // recurrent term and total drive
        rec_rnd = mul_p + (PW'(1) <<< 33);
        rec     = rec_rnd[56:34];
        t_val   = 25'(rec) + 25'(drive_q) - $signed(25'(inh_reg)) - 25'(xinh_reg);
        // leaky update, rounded and saturated
        lk_sum  = lk_reg + mul_p + (PW'(1) <<< 15);
        a_wide  = lk_sum[56:16];
        if (a_wide > 41'sd32767)
            a_sat = 16'sd32767;
        else if (a_wide < -41'sd32768)
            a_sat = -16'sd32768;
        else
            a_sat = a_wide[15:0];
        // magnitude of the sigmoid argument
        mag     = mul_p[PW-1] ? -mul_p : mul_p;
        // interpolation result
        rt_rnd  = mul_p + (use_sig_reg ? (PW'(1) <<< 18) : PW'(32));
        rt_sh   = use_sig_reg ? rt_rnd[34:19] : rt_rnd[21:6];
        v17     = sat_reg ? {1'b0, tab_top} : ({1'b0, tab_lo} + {1'b0, rt_sh});
        rate17  = (use_sig_reg && neg_reg) ? (17'h10000 - v17) : v17;
        if (!use_sig_reg && zero_reg)
            rate_val = 16'd0;
        else
            rate_val = rate17[15:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_word.cmd == drrn_pkg::CMD_CLEAR)
                    state_next = ST_SWEEP;
                else if (in_acc && in_word.cmd == drrn_pkg::CMD_STEP)
                    state_next = ST_SUM;
            end
            ST_SWEEP:
            begin
                if (sweep_reg == SW'(DL_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                if (cnt_reg == (CW+1)'(CELLS) && !sum_v_reg)
                    state_next = ST_INH;
            end
            ST_INH:   state_next = ST_INH_W;
            ST_INH_W: state_next = ST_MAC;
            ST_MAC:
            begin
                if (k_reg == KW'(CONNECTIONS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = ST_REC;
            end
            ST_REC:   state_next = ST_REC_W;
            ST_REC_W: state_next = ST_LK1;
            ST_LK1:   state_next = ST_LK2;
            ST_LK2:   state_next = ST_LK3;
            ST_LK3:   state_next = ST_RT1;
            ST_RT1:   state_next = ST_RT2;
            ST_RT2:   state_next = ST_RT3;
            ST_RT3:   state_next = ST_RT4;
            ST_RT4:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                    state_next = (c_reg == CW'(CELLS - 1)) ? ST_WB : ST_MAC;
            end
            ST_WB:
            begin
                if (cnt_reg == (CW+1)'(CELLS) && !wb_v_reg)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_reg    <= drrn_pkg::LEAK_RST;
            rscale_reg  <= drrn_pkg::REC_SCALE_RST;
            ginh_reg    <= '0;
            xinh_reg    <= '0;
            use_sig_reg <= 1'b1;
            beta_reg    <= drrn_pkg::SIG_GAIN_RST;
            alpha_reg   <= '0;
            dlen_reg    <= 5'd1;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                drrn_pkg::REG_LEAK:      leak_reg    <= cfg_data;
                drrn_pkg::REG_REC_SCALE: rscale_reg  <= cfg_data;
                drrn_pkg::REG_GLOB_INH:  ginh_reg    <= cfg_data;
                drrn_pkg::REG_EXT_INH:   xinh_reg    <= $signed(cfg_data);
                drrn_pkg::REG_USE_SIG:   use_sig_reg <= cfg_data[0];
                drrn_pkg::REG_SIG_GAIN:  beta_reg    <= cfg_data;
                drrn_pkg::REG_SIG_THR:   alpha_reg   <= $signed(cfg_data);
                drrn_pkg::REG_DELAY_LEN: dlen_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_all_reg <= 1'b1;
            sweep_reg     <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            head_reg      <= '0;
            sum_v_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            wb_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_v_reg <= 1'b0;
            wb_v_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    sweep_reg <= '0;
                    cnt_reg   <= '0;
                    // clear also rewinds the delay head
                    if (in_acc && in_word.cmd == drrn_pkg::CMD_CLEAR)
                    begin
                        sweep_all_reg <= 1'b0;
                        head_reg      <= '0;
                    end
                end
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_reg + SW'(1);
                end
                ST_SUM:
                begin
                    if (cnt_reg != (CW+1)'(CELLS))
                    begin
                        cnt_reg   <= cnt_reg + (CW+1)'(1);
                        sum_v_reg <= 1'b1;
                    end
                    c_reg <= '0;
                    k_reg <= '0;
                end
                ST_MAC:
                begin
                    v1_reg <= 1'b1;
                    k_reg  <= k_reg + KW'(1);
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        c_reg         <= c_reg + CW'(1);
                        k_reg         <= '0;
                        cnt_reg       <= '0;
                    end
                end
                ST_RT4:
                begin
                    out_valid_reg <= 1'b1;
                end
                ST_WB:
                begin
                    if (cnt_reg != (CW+1)'(CELLS))
                    begin
                        cnt_reg  <= cnt_reg + (CW+1)'(1);
                        wb_v_reg <= 1'b1;
                    end
                    else if (!wb_v_reg)
                        head_reg <= head_after;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        w_d_reg     <= w_q;
        wb_cell_reg <= cnt_reg[CW-1:0];
        if (state_reg == ST_IDLE)
            sum_reg <= '0;
        else if (sum_v_reg)
            sum_reg <= sum_reg + SUMW'(rate_q);
        if (state_reg == ST_INH_W)
        begin
            inh_reg <= 17'((mul_p + (PW'(1) <<< 23)) >>> 24);
        end
        if (state_reg == ST_INH_W || (state_reg == ST_OUT && out_ready))
            acc_reg <= '0;
        else if (v3_reg)
            acc_reg <= acc_reg + AW'(mul_p);
        if (state_reg == ST_REC_W)
            t_reg <= t_val;
        if (state_reg == ST_LK2)
            lk_reg <= mul_p;
        if (state_reg == ST_LK3)
            act_new_reg <= a_sat;
        // table index and fraction
        if (state_reg == ST_RT2)
        begin
            if (use_sig_reg)
            begin
                neg_reg  <= mul_p[PW-1];
                sat_reg  <= (mag >= PW'(4194304));
                zero_reg <= 1'b0;
                idx_reg  <= mag[21:18];
                frac_reg <= {mag[17:0], 1'b0};
            end
            else
            begin
                neg_reg  <= 1'b0;
                sat_reg  <= (act_new_reg >= 16'sd1024);
                zero_reg <= (act_new_reg <= 16'sd0);
                idx_reg  <= act_new_reg[9:6];
                frac_reg <= {13'd0, act_new_reg[5:0]};
            end
        end
        // result word
        if (state_reg == ST_RT4)
        begin
            out_word_reg.cell_index     <= 5'(c_reg);
            out_word_reg.activation_out <= act_new_reg;
            out_word_reg.rate_out       <= rate_val;
            out_word_reg.last           <= (c_reg == CW'(CELLS - 1));
        end
    end

    // weight and source memory
    always_ff @(posedge clk)
    begin
        if (in_acc && in_word.cmd == drrn_pkg::CMD_LOAD && load_ok)
        begin
            wt_mem[{CW'(in_word.target_cell), KW'(in_word.slot)}]  <= in_word.value;
            src_mem[{CW'(in_word.target_cell), KW'(in_word.slot)}] <= CW'(in_word.source_cell);
        end
        w_q <= $signed(wt_mem[{c_reg, k_reg}]);
        s_q <= src_mem[{c_reg, k_reg}];
    end

    // delay line memory
    logic           dl_we;
    logic [SW-1:0]  dl_waddr;
    logic [15:0]    dl_wdata;
    always_comb
    begin
        dl_we    = (state_reg == ST_SWEEP) || wb_v_reg;
        dl_waddr = (state_reg == ST_SWEEP) ? sweep_reg : {wb_cell_reg, head_use};
        dl_wdata = (state_reg == ST_SWEEP) ? 16'd0 : rate_q;
    end

    always_ff @(posedge clk)
    begin
        if (dl_we)
            dl_mem[dl_waddr] <= dl_wdata;
        r_q <= dl_mem[{s_q, head_use}];
    end

    // per-cell memories: rates, activations, drives
    logic           sweep_row;
    logic [CW-1:0]  sweep_cell;
    assign sweep_row  = (state_reg == ST_SWEEP) && (sweep_reg[DW-1:0] == '0);
    assign sweep_cell = sweep_reg[SW-1:DW];

    always_ff @(posedge clk)
    begin
        if (sweep_row)
            rate_mem[sweep_cell] <= '0;
        else if (state_reg == ST_RT4)
            rate_mem[c_reg] <= rate_val;
        rate_q <= rate_mem[cnt_reg[CW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (sweep_row)
            act_mem[sweep_cell] <= '0;
        else if (state_reg == ST_LK3)
            act_mem[c_reg] <= a_sat;
        act_q <= $signed(act_mem[c_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (sweep_row && sweep_all_reg)
            drive_mem[sweep_cell] <= '0;
        else if (in_acc && in_word.cmd == drrn_pkg::CMD_DRIVE && drive_ok)
            drive_mem[CW'(in_word.target_cell)] <= in_word.value;
        drive_q <= $signed(drive_mem[c_reg]);
    end

    // checks
    a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result word is pending");

    a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.last) |-> (out_word.cell_index == 5'(CELLS - 1)))
        else $error("last flag on a cell other than the final one");

    a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REC) |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("recurrent scaling started with products in flight");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(head_reg) < MAX_DELAY))
        else $error("delay head beyond the delay memory");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
        else $error("result word dropped or changed while stalled");

endmodule

// ===== dv/delayed_recurrent_rate_network_step_test.sv =====
// ----------------------------------------------------------------------------
// delayed_recurrent_rate_network_step_test
// Self-checking bench for the recurrent rate network: every weight slot is
// loaded first, then a directed sequence and random command streams run
// under several register settings. A scoreboard predicts every cell result
// of each step and compares them, field by field, with the block's output.
// ----------------------------------------------------------------------------
module delayed_recurrent_rate_network_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NC = 32;
    localparam int NK = 32;
    localparam int ND = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE = 700;

    // network state mirror and step predictor
    class net_scoreboard;
        logic signed [15:0]     wt [NC][NK];
        logic [4:0]             src [NC][NK];
        logic signed [15:0]     drv [NC];
        logic signed [15:0]     act [NC];
        logic [15:0]            rt [NC];
        logic [15:0]            dly [NC][ND];
        int                     head;
        logic [15:0]            regs [8];
        drrn_pkg::out_word_t    pending [$];
        int                     errors;

        function new();
            regs[drrn_pkg::REG_LEAK]      = 16'd6554;
            regs[drrn_pkg::REG_REC_SCALE] = 16'd4096;
            regs[drrn_pkg::REG_GLOB_INH]  = 16'd0;
            regs[drrn_pkg::REG_EXT_INH]   = 16'd0;
            regs[drrn_pkg::REG_USE_SIG]   = 16'd1;
            regs[drrn_pkg::REG_SIG_GAIN]  = 16'd4096;
            regs[drrn_pkg::REG_SIG_THR]   = 16'd0;
            regs[drrn_pkg::REG_DELAY_LEN] = 16'd1;
            errors = 0;
            foreach (drv[c]) drv[c] = '0;
            clear_net();
        endfunction

        function void clear_net();
            foreach (act[c]) act[c] = '0;
            foreach (rt[c]) rt[c] = '0;
            foreach (dly[c, d]) dly[c][d] = '0;
            head = 0;
        endfunction

        function void note_register(logic [3:0] idx, logic [15:0] data);
            case (idx)
                drrn_pkg::REG_USE_SIG:   regs[idx] = {15'd0, data[0]};
                drrn_pkg::REG_DELAY_LEN: regs[idx] = {11'd0, data[4:0]};
                default: if (idx < 8) regs[idx] = data;
            endcase
        endfunction

        // interpolate between table samples, s fraction bits
        function longint lookup(bit tanh_sel, longint idx, longint fr, int s);
            longint lo, hi;
            lo = tanh_sel ? longint'(drrn_pkg::TANH_TAB[idx]) : longint'(drrn_pkg::SIG_TAB[idx]);
            hi = tanh_sel ? longint'(drrn_pkg::TANH_TAB[idx+1])
                          : longint'(drrn_pkg::SIG_TAB[idx+1]);
            return lo + (((hi - lo) * fr + (64'sd1 <<< (s - 1))) >>> s);
        endfunction

        function logic [15:0] rate_fn(logic signed [15:0] a);
            longint d, x, ax, v;
            if (regs[drrn_pkg::REG_USE_SIG][0])
            begin
                d = longint'(a) - longint'($signed(regs[drrn_pkg::REG_SIG_THR]));
                x = 2 * longint'(regs[drrn_pkg::REG_SIG_GAIN]) * d;
                ax = (x < 0) ? -x : x;
                if (ax >= (64'sd8 <<< 20))
                    v = longint'(drrn_pkg::SIG_TAB[16]);
                else
                    v = lookup(1'b0, ax >>> 19, ax & ((64'sd1 <<< 19) - 1), 19);
                return (x < 0) ? 16'(65536 - v) : 16'(v);
            end
            if (a <= 0)
                return 16'd0;
            if (a >= 1024)
                return drrn_pkg::TANH_TAB[16];
            return 16'(lookup(1'b1, longint'(a) >>> 6, longint'(a) & 63, 6));
        endfunction

        // apply one accepted input word
        function void note_input(drrn_pkg::in_word_t w);
            int len, hd;
            longint sum, inh, ext, e, acc, t, a;
            logic signed [15:0] nact [NC];
            drrn_pkg::out_word_t o;
            case (w.cmd)
                drrn_pkg::CMD_CLEAR: clear_net();
                drrn_pkg::CMD_LOAD:
                begin
                    wt[w.target_cell][w.slot] = w.value;
                    src[w.target_cell][w.slot] = w.source_cell;
                end
                drrn_pkg::CMD_DRIVE: drv[w.target_cell] = w.value;
                default:
                begin
                    len = int'(regs[drrn_pkg::REG_DELAY_LEN]);
                    if (len < 1) len = 1;
                    if (len > ND) len = ND;
                    hd = (head < len) ? head : 0;
                    sum = 0;
                    foreach (rt[c]) sum += longint'(rt[c]);
                    inh = (longint'(regs[drrn_pkg::REG_GLOB_INH]) * sum + (64'sd1 <<< 23))
                          >>> 24;
                    ext = longint'($signed(regs[drrn_pkg::REG_EXT_INH]));
                    e = longint'(regs[drrn_pkg::REG_LEAK]);
                    for (int c = 0; c < NC; c++)
                    begin
                        acc = 0;
                        for (int k = 0; k < NK; k++)
                            acc += longint'(wt[c][k]) * longint'(dly[src[c][k]][hd]);
                        t = ((acc * longint'(regs[drrn_pkg::REG_REC_SCALE]) + (64'sd1 <<< 33))
                             >>> 34) + longint'(drv[c]) - inh - ext;
                        a = ((65536 - e) * longint'(act[c]) + e * t + 32768) >>> 16;
                        if (a > 32767) a = 32767;
                        if (a < -32768) a = -32768;
                        nact[c] = 16'(a);
                    end
                    for (int c = 0; c < NC; c++)
                    begin
                        act[c] = nact[c];
                        rt[c] = rate_fn(nact[c]);
                        dly[c][hd] = rt[c];
                        o.cell_index = 5'(c);
                        o.activation_out = nact[c];
                        o.rate_out = rt[c];
                        o.last = (c == NC - 1);
                        pending.push_back(o);
                    end
                    hd++;
                    head = (hd >= len) ? 0 : hd;
                end
            endcase
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(drrn_pkg::out_word_t g);
            drrn_pkg::out_word_t x;
            if (pending.size() == 0)
            begin
                report("unexpected word, cell", int'(g.cell_index), -1);
                return;
            end
            x = pending.pop_front();
            if (g.cell_index !== x.cell_index)
                report("cell_index", int'(g.cell_index), int'(x.cell_index));
            if (g.activation_out !== x.activation_out)
                report($sformatf("activation cell %0d", x.cell_index),
                       int'(g.activation_out), int'(x.activation_out));
            if (g.rate_out !== x.rate_out)
                report($sformatf("rate cell %0d", x.cell_index),
                       int'(g.rate_out), int'(x.rate_out));
            if (g.last !== x.last) report("last", int'(g.last), int'(x.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [drrn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [drrn_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    drrn_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    drrn_pkg::out_word_t out_word;

    net_scoreboard sb;
    int cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    delayed_recurrent_rate_network_step DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("delayed_recurrent_rate_network_step verification failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check(out_word);

    // receiver stall pattern, changing mode every stretch
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((cycles % 5) != 0);
        endcase
    end

    // one input word, with bursty gaps between words
    task send_word(drrn_pkg::in_word_t w);
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 10);
        end
        else
            burst_left--;
    endtask

    task idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until all results have come and the block has settled
    task drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_reg(logic [3:0] idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.note_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function drrn_pkg::in_word_t make_word(logic [1:0] cmd, int tgt, int sl, int sc, int val);
        drrn_pkg::in_word_t w;
        w.cmd = cmd;
        w.target_cell = 5'(tgt);
        w.slot = 5'(sl);
        w.source_cell = 5'(sc);
        w.value = 16'(val);
        return w;
    endfunction

    function drrn_pkg::in_word_t random_word();
        int r, v;
        r = $urandom_range(0, 99);
        v = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1200) - 600;
        if (r < 8)
            return make_word(drrn_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        if (r < 35)
            return make_word(drrn_pkg::CMD_LOAD, $urandom, $urandom, $urandom, v);
        if (r < 55)
            return make_word(drrn_pkg::CMD_DRIVE, $urandom, $urandom, $urandom,
                             ($urandom_range(0, 7) == 0) ? $urandom
                                                         : $urandom_range(0, 1600) - 400);
        return make_word(drrn_pkg::CMD_STEP, $urandom, $urandom, $urandom, $urandom);
    endfunction

    initial
    begin
        logic [15:0] setting [8];
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every weight slot gets written before any step
        for (int c = 0; c < NC; c++)
            for (int k = 0; k < NK; k++)
                send_word(make_word(drrn_pkg::CMD_LOAD, c, k, $urandom,
                                    $urandom_range(0, 2000) - 1000));

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_input();
            drain();
            case (ph)
                0: setting = '{16'd6554, 16'd4096, 16'd0, 16'd0, 16'd1, 16'd4096,
                               16'd0, 16'd1};
                1: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF,
                               16'hFFFF, 16'h7FFF, 16'd16};
                2: setting = '{16'd0, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'd0,
                               16'h8000, 16'd0};
                default:
                begin
                    setting[drrn_pkg::REG_LEAK] = 16'($urandom_range(2000, 40000));
                    setting[drrn_pkg::REG_REC_SCALE] = 16'($urandom_range(0, 20000));
                    setting[drrn_pkg::REG_GLOB_INH] = 16'($urandom_range(0, 3000));
                    setting[drrn_pkg::REG_EXT_INH] = 16'($urandom_range(0, 512) - 256);
                    setting[drrn_pkg::REG_USE_SIG] = 16'($urandom);
                    setting[drrn_pkg::REG_SIG_GAIN] = 16'($urandom_range(0, 16000));
                    setting[drrn_pkg::REG_SIG_THR] = 16'($urandom_range(0, 1024) - 512);
                    setting[drrn_pkg::REG_DELAY_LEN] =
                        (ph == 3) ? 16'($urandom_range(17, 31)) :
                                    16'($urandom_range(2, 16)) | 16'hFFE0;
                end
            endcase
            for (int i = 0; i < 8; i++)
                write_reg(4'(i), setting[i]);

            if (ph == 0)
            begin
                // directed: field extremes and every command
                send_word(make_word(drrn_pkg::CMD_DRIVE, 0, 0, 0, 32767));
                send_word(make_word(drrn_pkg::CMD_DRIVE, 31, 31, 31, -32768));
                send_word(make_word(drrn_pkg::CMD_STEP, 0, 0, 0, 0));
                send_word(make_word(drrn_pkg::CMD_LOAD, 0, 0, 31, 32767));
                send_word(make_word(drrn_pkg::CMD_LOAD, 31, 31, 0, -32768));
                send_word(make_word(drrn_pkg::CMD_STEP, 31, 31, 31, -1));
                send_word(make_word(drrn_pkg::CMD_STEP, 0, 0, 0, 0));
                send_word(make_word(drrn_pkg::CMD_CLEAR, 31, 31, 31, -1));
                send_word(make_word(drrn_pkg::CMD_STEP, 0, 0, 0, 0));
                send_word(make_word(drrn_pkg::CMD_DRIVE, 5, 0, 0, 300));
                send_word(make_word(drrn_pkg::CMD_DRIVE, 0, 0, 0, 0));
                send_word(make_word(drrn_pkg::CMD_DRIVE, 31, 0, 0, -200));
                send_word(make_word(drrn_pkg::CMD_STEP, 0, 0, 0, 0));
                send_word(make_word(drrn_pkg::CMD_STEP, 0, 0, 0, 0));
                send_word(make_word(drrn_pkg::CMD_CLEAR, 0, 0, 0, 0));
                send_word(make_word(drrn_pkg::CMD_CLEAR, 0, 0, 0, 0));
                send_word(make_word(drrn_pkg::CMD_STEP, 0, 0, 0, 0));
            end
            for (int i = 0; i < 55; i++)
                send_word(random_word());
        end

        idle_input();
        drain();
        if (sb.errors == 0)
            $display("delayed_recurrent_rate_network_step verification clean");
        else
            $display("delayed_recurrent_rate_network_step verification failed");
        $finish;
    end

endmodule
